FILE: rtl/tdpt_pkg.sv
// tdpt_pkg: command and status types shared by the prime test controller
// and datapath. no dependencies.
package tdpt_pkg;

   typedef struct packed {
      logic load;       // capture number, divisor 2, square 4
      logic div_init;   // clear remainder, load dividend shifter
      logic div_step;   // one restoring division step
      logic next_div;   // advance divisor and its square
   } tdpt_cmd_type;

   typedef struct packed {
      logic lt_two;     // number below 2
      logic sq_le_n;    // divisor squared does not exceed number
      logic div_done;   // last division step in progress
      logic rem_zero;   // remainder of finished trial is zero
   } tdpt_status_type;

endpackage

FILE: rtl/tdpt_datapath.sv
// tdpt_datapath: number, trial divisor, running square and a bit-serial
// restoring remainder unit. depends on tdpt_pkg.
module tdpt_datapath #(
   parameter int VALUE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [VALUE_BITS-1:0]     req_number,
   input  tdpt_pkg::tdpt_cmd_type    cmd,
   output tdpt_pkg::tdpt_status_type status
);
   import tdpt_pkg::*;

   localparam int SQ_BITS  = 2 * VALUE_BITS;
   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

   logic [VALUE_BITS-1:0] number_ff, number_in;
   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;
   logic [SQ_BITS-1:0]    square_ff, square_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [CNT_BITS-1:0]   step_ff, step_in;

   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   trial_sub;

   assign trial     = {rem_ff, shift_ff[VALUE_BITS-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};

   always_comb begin
      number_in  = number_ff;
      divisor_in = divisor_ff;
      square_in  = square_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      step_in    = step_ff;
      if (cmd.load) begin
         number_in  = req_number;
         divisor_in = VALUE_BITS'(2);
         square_in  = SQ_BITS'(4);
      end
      if (cmd.div_init) begin
         rem_in   = '0;
         shift_in = number_ff;
         step_in  = '0;
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = trial_sub[VALUE_BITS-1:0];
         end else begin
            rem_in = trial[VALUE_BITS-1:0];
         end
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         step_in  = step_ff + CNT_BITS'(1);
      end
      if (cmd.next_div) begin
         // (d+1)^2 = d^2 + 2d + 1
         square_in  = square_ff + {{(SQ_BITS - VALUE_BITS - 1){1'b0}}, divisor_ff, 1'b0}
                      + SQ_BITS'(1);
         divisor_in = divisor_ff + VALUE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_ff  <= '0;
         divisor_ff <= VALUE_BITS'(2);
         square_ff  <= SQ_BITS'(4);
         rem_ff     <= '0;
         shift_ff   <= '0;
         step_ff    <= '0;
      end else begin
         number_ff  <= number_in;
         divisor_ff <= divisor_in;
         square_ff  <= square_in;
         rem_ff     <= rem_in;
         shift_ff   <= shift_in;
         step_ff    <= step_in;
      end
   end

   always_comb begin
      status          = '0;
      status.lt_two   = number_ff < VALUE_BITS'(2);
      status.sq_le_n  = square_ff <= {{(SQ_BITS - VALUE_BITS){1'b0}}, number_ff};
      status.div_done = step_ff == LAST_STEP;
      status.rem_zero = rem_ff == '0;
   end

endmodule

FILE: rtl/tdpt_controller.sv
// tdpt_controller: sequencer for the trial division loop and result strobe.
// depends on tdpt_pkg.
module tdpt_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output logic                      rsp_valid,
   output logic                      rsp_is_prime,
   output tdpt_pkg::tdpt_cmd_type    cmd,
   input  tdpt_pkg::tdpt_status_type status
);
   import tdpt_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_TEST  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       prime_ff, prime_in;

   assign busy         = state_ff != ST_IDLE;
   assign rsp_valid    = valid_ff;
   assign rsp_is_prime = prime_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      prime_in = prime_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.lt_two) begin
               valid_in = 1'b1;
               prime_in = 1'b0;
               state_in = ST_IDLE;
            end else if (!status.sq_le_n) begin
               valid_in = 1'b1;
               prime_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.rem_zero) begin
               valid_in = 1'b1;
               prime_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         prime_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         prime_ff <= prime_in;
      end
   end

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start a test");

   a_no_back_to_back_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   a_prime_only_from_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_prime) |-> ($past(state_ff) == ST_CHECK))
      else $error("prime result not issued from square check");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while still busy");

endmodule

FILE: rtl/trial_division_prime_test_top.sv
// trial_division_prime_test_top: primality test by trial division.
// instantiates tdpt_controller and tdpt_datapath; depends on tdpt_pkg.
//
//   channel   ports                          direction
//   request   start, busy, req_number        in (busy out)
//   result    rsp_valid, rsp_is_prime        out
//
// a request beat is taken when start is high and busy is low.
// each trial divisor takes a square check, VALUE_BITS steps of the bit-serial
// remainder unit and a zero test.
// the result is registered from the square check for numbers below 2 and for a
// prime once the divisor's square exceeds it, and from the zero test for a
// composite whose trial divisor divides it.
// reset is synchronous and leaves the block idle; results cannot be stalled.
module trial_division_prime_test_top #(
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_number,
   output logic                  rsp_valid,
   output logic                  rsp_is_prime
);
   import tdpt_pkg::*;

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   tdpt_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   tdpt_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_number (req_number),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: dv/prime_verdict_checker.sv
// prime_verdict_checker: watches the request and result channels of
// trial_division_prime_test_top, predicts each verdict and compares in order.
// standalone, no package needed; failure and pending counts go to the tb top.
`timescale 1ns / 100ps

module prime_verdict_checker #(
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [VALUE_BITS-1:0] req_number,
   input  logic                  rsp_valid,
   input  logic                  rsp_is_prime,
   output int                    error_count,
   output int                    pending_count
);

   typedef struct {
      logic [VALUE_BITS-1:0] number;
      bit                    is_prime;
   } verdict_t;

   verdict_t verdicts_due[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic bit trial_divide_verdict(logic [VALUE_BITS-1:0] value);
      longint unsigned n;
      longint unsigned divisor;
      n = value;
      if (n < 2) return 1'b0;
      for (divisor = 2; divisor * divisor <= n; divisor++) begin
         if (n % divisor == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t: prime_verdict_checker: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      verdict_t due;
      verdict_t taken;
      if (reset) begin
         verdicts_due.delete();
      end else begin
         if (rsp_valid) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("result beat is_prime=%b with none pending",
                                         rsp_is_prime));
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_is_prime !== due.is_prime)
                  report_mismatch($sformatf("number %0d: is_prime %b, want %b",
                                            due.number, rsp_is_prime, due.is_prime));
            end
         end
         if (start && !busy) begin
            taken.number   = req_number;
            taken.is_prime = trial_divide_verdict(req_number);
            verdicts_due.push_back(taken);
         end
      end
      pending_count = verdicts_due.size();
   end

endmodule

FILE: dv/tb_trial_division_prime_test_top.sv
// tb_trial_division_prime_test_top: stimulus and verdict for the trial division
// prime test; depends on trial_division_prime_test_top and prime_verdict_checker.
`timescale 1ns / 100ps

module tb_trial_division_prime_test_top;

   localparam int VALUE_BITS   = 16;
   localparam int RANDOM_BEATS = 120;
   localparam int CYCLE_LIMIT  = 3_000_000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [VALUE_BITS-1:0] req_number;
   logic                  rsp_valid;
   logic                  rsp_is_prime;
   int                    error_count;
   int                    pending_count;
   int                    cycle_count;
   bit                    steady;

   trial_division_prime_test_top #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

   prime_verdict_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_is_prime  (rsp_is_prime),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_trial_division_prime_test_top: done, errors");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_number(logic [VALUE_BITS-1:0] value);
      start      <= 1'b1;
      req_number <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 4);
      else gap = $urandom_range(15, 300);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // mostly small numbers, since large primes take many trial divisors
   function automatic logic [VALUE_BITS-1:0] pick_number();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return VALUE_BITS'($urandom_range(0, 255));
      else if (roll < 70) return VALUE_BITS'($urandom_range(256, 4095));
      else if (roll < 95) return VALUE_BITS'($urandom_range(0, 65535));
      else return VALUE_BITS'($urandom_range(60000, 65535) | 1);
   endfunction

   initial begin
      logic [VALUE_BITS-1:0] directed[$];
      reset      = 1'b1;
      start      = 1'b0;
      req_number = '0;
      steady     = 1'b0;
      directed   = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25,
                     16'd49, 16'd97, 16'd32768, 16'd32749, 16'd63001, 16'd65025,
                     16'd65521, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA, 16'd1};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         send_number(directed[i]);
         idle_gap();
      end

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 25 == 0) steady = ($urandom_range(0, 2) == 0);
         send_number(pick_number());
         idle_gap();
      end
      start <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (error_count == 0)
         $display("tb_trial_division_prime_test_top: done, clean");
      else
         $display("tb_trial_division_prime_test_top: done, errors");
      $finish;
   end

endmodule
